// ===== hdl/hbp_pkg.sv =====
package hbp_pkg;

    localparam int STREAM_BITS_DEF  = 4096;
    localparam int CODE_LEN_MAX_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int OP_W     = 2;
    localparam int SYM_FW   = 8;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 6;
    localparam int COUNT_FW = 13;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SYM_FW-1:0] symbol;
        logic [WORD_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                is_report;
        logic [COUNT_FW-1:0] bits_total;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [SYM_FW-1:0] sym;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } t_tbl_req;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } t_tbl_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT,
        ST_FIN_BYTE,
        ST_FIN_REPORT
    } t_state;

endpackage

// ===== hdl/hbp_ram.sv =====
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/hbp_table.sv =====
module hbp_table #(
    parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF,
    parameter int CODE_LEN_MAX = hbp_pkg::CODE_LEN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hbp_pkg::t_tbl_req i_req,
    output hbp_pkg::t_tbl_rsp o_rsp
);
    import hbp_pkg::*;

    localparam int SYM_W = $clog2(SYMBOL_COUNT);
    localparam int ENT_W = WORD_W + LEN_W;

    logic [SYMBOL_COUNT-1:0] r_valid;
    logic                    r_hit;
    logic                    w_in_range;
    logic [SYM_W-1:0]        w_idx;
    logic [LEN_W-1:0]        w_sat_len;
    logic [ENT_W-1:0]        w_rd_data;

    assign w_in_range = {1'b0, i_req.sym} < (SYM_FW + 1)'(SYMBOL_COUNT);
    assign w_idx      = i_req.sym[SYM_W-1:0];
    assign w_sat_len  = (i_req.len > LEN_W'(CODE_LEN_MAX)) ? LEN_W'(CODE_LEN_MAX) : i_req.len;

    hbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.wr && w_in_range),
        .i_wr_addr (w_idx),
        .i_wr_data ({i_req.word, w_sat_len}),
        .i_rd_en   (i_req.rd),
        .i_rd_addr (w_idx),
        .o_rd_data (w_rd_data)
    );

    // valid bits stand in for the cleared length table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_req.wr && w_in_range) begin
                r_valid[w_idx] <= 1'b1;
            end
            if (i_req.rd) begin
                r_hit <= w_in_range && r_valid[w_idx];
            end
        end
    end

    assign o_rsp.word = w_rd_data[ENT_W-1:LEN_W];
    assign o_rsp.len  = r_hit ? w_rd_data[LEN_W-1:0] : '0;

endmodule

// ===== hdl/huffman_bit_packer_top.sv =====
// channel | direction | payload    | handshake
// in      | input     | t_in_item  | i_in_valid / o_in_stall
// out     | output     | t_out_item | o_out_valid / i_out_stall
//
// load writes the table entry; encode reads the table and then emits each completed
// byte (up to 4) one at a time through the single output register.
// finish emits the partial byte, if bits are pending, and then the report item.
// reset clears the length table at once through per-entry valid bits.
// a stall on the output holds the output register and the current sequence;
// a new item is taken while the last result still waits in the register.
module huffman_bit_packer_top #(
    parameter int STREAM_BITS  = hbp_pkg::STREAM_BITS_DEF,
    parameter int CODE_LEN_MAX = hbp_pkg::CODE_LEN_MAX_DEF,
    parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbp_pkg::t_in_item  i_in_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output hbp_pkg::t_out_item o_out_data,
    output logic               o_out_valid,
    input  logic               i_out_stall
);
    import hbp_pkg::*;

    localparam int CNT_W = $clog2(STREAM_BITS + 1);
    localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    t_state    r_state, n_state;
    logic [7:0]          r_pending, n_pending;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [31:0]         r_acc, n_acc;
    logic [2:0]          r_nbytes, n_nbytes;
    t_out_item           r_out, n_out;
    logic                r_out_valid;
    logic                w_load;

    t_tbl_req w_req;
    t_tbl_rsp w_rsp;

    logic             w_in_acc;
    logic             w_out_free;
    logic [LEN_W-1:0] w_clen;
    logic [SUM_W-1:0] w_sum;
    logic             w_over;
    logic [2:0]       w_fill;
    logic [31:0]      w_mask;
    logic [39:0]      w_acc;
    logic [5:0]       w_total;
    logic [2:0]       w_nbytes;
    logic             w_append;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_req.wr   = w_in_acc && (i_in_data.op == OP_LOAD);
    assign w_req.rd   = w_in_acc && (i_in_data.op == OP_ENCODE);
    assign w_req.sym  = i_in_data.symbol;
    assign w_req.word = i_in_data.code_bits;
    assign w_req.len  = i_in_data.code_length;

    hbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .CODE_LEN_MAX (CODE_LEN_MAX)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // lookup datapath
    assign w_clen   = w_rsp.len;
    assign w_sum    = SUM_W'(r_count) + SUM_W'(w_clen);
    assign w_over   = w_sum > SUM_W'(STREAM_BITS);
    assign w_fill   = r_count[2:0];
    assign w_mask   = 32'hFFFF_FFFF >> (6'd32 - w_clen);
    assign w_acc    = ({8'b0, w_rsp.word & w_mask} << w_fill) | {32'b0, r_pending};
    assign w_total  = 6'(w_fill) + 6'(w_clen);
    assign w_nbytes = w_total[5:3];
    assign w_append = (r_err == STATUS_OK) && (w_clen != '0) && !w_over;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.op == OP_ENCODE) begin
                        n_state = ST_LOOKUP;
                    end else if (i_in_data.op == OP_FINISH) begin
                        n_state = (r_count[2:0] != 3'd0) ? ST_FIN_BYTE : ST_FIN_REPORT;
                    end
                end
            end
            ST_LOOKUP: begin
                n_state = (w_append && (w_nbytes != 3'd0)) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (w_out_free && (r_nbytes == 3'd1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIN_BYTE: begin
                if (w_out_free) begin
                    n_state = ST_FIN_REPORT;
                end
            end
            ST_FIN_REPORT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        n_pending  = r_pending;
        n_count    = r_count;
        n_err      = r_err;
        n_acc      = r_acc;
        n_nbytes   = r_nbytes;
        n_out      = r_out;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_LOOKUP: begin
                if (r_err == STATUS_OK) begin
                    if (w_clen == '0) begin
                        n_err = STATUS_UNUSED;
                    end else if (w_over) begin
                        n_err = STATUS_OVERFLOW;
                    end else begin
                        n_acc     = w_acc[31:0];
                        n_nbytes  = w_nbytes;
                        n_pending = w_acc[{w_nbytes, 3'b000} +: 8];
                        n_count   = w_sum[CNT_W-1:0];
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load          = 1'b1;
                    n_out           = '0;
                    n_out.data_byte = r_acc[7:0];
                    n_out.last      = (r_nbytes == 3'd1);
                    n_acc           = r_acc >> 8;
                    n_nbytes        = r_nbytes - 3'd1;
                end
            end
            ST_FIN_BYTE: begin
                if (w_out_free) begin
                    w_load          = 1'b1;
                    n_out           = '0;
                    n_out.data_byte = r_pending;
                end
            end
            ST_FIN_REPORT: begin
                if (w_out_free) begin
                    w_load           = 1'b1;
                    n_out            = '0;
                    n_out.is_report  = 1'b1;
                    n_out.bits_total = COUNT_FW'(r_count);
                    n_out.status     = r_err;
                    n_out.last       = 1'b1;
                    n_pending        = '0;
                    n_count          = '0;
                    n_err            = STATUS_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= '0;
            r_count     <= '0;
            r_err       <= STATUS_OK;
            r_nbytes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_err     <= n_err;
            r_nbytes  <= n_nbytes;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

endmodule
